[src/psr_pkg.sv]
// Shared types and constants for the prime sieve round block.
// Used by the controller, the datapath and the top level; depends on nothing.
package psr_pkg;

    localparam int REQ_W   = 2;
    localparam int INDEX_W = 13;
    localparam int BYTE_W  = 8;
    localparam int NUM_W   = 16;
    // Number being scanned or cleared; one bit above NUM_W so it can pass max.
    localparam int WALK_W  = NUM_W + 1;
    localparam int BADDR_W = WALK_W - 3;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ROUND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [NUM_W-1:0] MAX_NUMBER_RESET = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input fields
        logic byte_write; // store the input byte
        logic rd_issue;   // read the addressed byte
        logic rd_capture; // keep the byte read for the result
        logic srch_init;  // start the upward search above prime_in
        logic srch_issue; // read the byte under the search pointer
        logic srch_step;  // take the search result or move to the next byte
        logic clr_init;   // first multiple is twice the prime
        logic clr_issue;  // read the byte holding the current multiple
        logic clr_write;  // clear the multiple and advance
        logic out_load;   // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic srch_end;   // search pointer is past max_number
        logic srch_hit;   // current byte holds a candidate in range
        logic clr_end;    // nothing left to clear
        logic out_free;   // output register can take a result this cycle
    } status_t;

endpackage

[src/prime_sieve_round.sv]
// Top level of the prime sieve round block.
// Instantiates psr_ctrl and psr_datapath; types and codes come from psr_pkg.
//
// The block keeps a sieve bitmap in a single-port-read, single-port-write
// memory of BITMAP_BYTES bytes, where number n is bit n%8 of byte n/8. Every
// transaction on the s_ channel produces exactly one transaction on the m_
// channel. A byte write (req_type 0) goes from acceptance to the WRITE state,
// where the byte is stored, and then to FINISH, where its result enters the
// output register. A byte read (req_type 2) goes through RD_ADDR, which issues
// the memory read, and RD_DATA, which captures the byte, to FINISH. A sieve
// round (req_type 1) scans the bitmap bytes upward from prime_in + 1 until a
// set bit or max_number is reached, then clears the multiples of the resulting
// prime from twice the prime up to max_number, then goes to FINISH. The
// memory's read port is registered: each byte scanned is read and then
// checked, and each multiple is read and then written back. A result still
// held in the output register keeps the block in FINISH until it is taken.
// One transaction is worked on at a time; the next is accepted once the
// previous result sits in the output register, so a waiting result does not
// block the input. The memory has no reset: every byte that a read or a round
// touches must have been written first. max_number is written over the cfg_
// channel, which is always ready, and must only be written while the block is
// idle.
module prime_sieve_round #(
    parameter int BITMAP_BYTES = 8192
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write channel for max_number.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [psr_pkg::NUM_W-1:0]     cfg_max_number,
    // Request channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [psr_pkg::REQ_W-1:0]     s_req_type,
    input  logic [psr_pkg::INDEX_W-1:0]   s_byte_index,
    input  logic [psr_pkg::BYTE_W-1:0]    s_byte_value,
    input  logic [psr_pkg::NUM_W-1:0]     s_prime_in,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psr_pkg::BYTE_W-1:0]    m_read_data,
    output logic [psr_pkg::NUM_W-1:0]     m_prime_out,
    output logic                          m_found
);

    psr_pkg::cmd_t    cmd;
    psr_pkg::status_t status;

    // The register write never stalls.
    assign cfg_ready = 1'b1;

    // The controller sequences each transaction through the datapath.
    psr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds the bitmap, the walking pointers and the result.
    psr_datapath #(
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_max_number (cfg_max_number),
        .s_req_type     (s_req_type),
        .s_byte_index   (s_byte_index),
        .s_byte_value   (s_byte_value),
        .s_prime_in     (s_prime_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_prime_out    (m_prime_out),
        .m_found        (m_found),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

[src/psr_ctrl.sv]
// Controller state machine of the prime sieve round block.
// Depends on psr_pkg for the command and status structs and the request codes.
module psr_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic [psr_pkg::REQ_W-1:0] s_req_type,
    output logic                    s_ready,
    input  psr_pkg::status_t        status,
    output psr_pkg::cmd_t           cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_WRITE   = 4'd1;
    localparam logic [3:0] ST_RD_ADDR = 4'd2;
    localparam logic [3:0] ST_RD_DATA = 4'd3;
    localparam logic [3:0] ST_S_INIT  = 4'd4;
    localparam logic [3:0] ST_S_READ  = 4'd5;
    localparam logic [3:0] ST_S_CHECK = 4'd6;
    localparam logic [3:0] ST_C_INIT  = 4'd7;
    localparam logic [3:0] ST_C_READ  = 4'd8;
    localparam logic [3:0] ST_C_WRITE = 4'd9;
    localparam logic [3:0] ST_FINISH  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_req_type)
                        psr_pkg::REQ_WRITE: state_next = ST_WRITE;
                        psr_pkg::REQ_ROUND: state_next = ST_S_INIT;
                        psr_pkg::REQ_READ:  state_next = ST_RD_ADDR;
                        default:            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_WRITE: begin
                cmd.byte_write = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_RD_ADDR: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_S_INIT: begin
                cmd.srch_init = 1'b1;
                state_next    = ST_S_READ;
            end
            ST_S_READ: begin
                if (status.srch_end) begin
                    state_next = ST_C_INIT;
                end else begin
                    cmd.srch_issue = 1'b1;
                    state_next     = ST_S_CHECK;
                end
            end
            ST_S_CHECK: begin
                cmd.srch_step = 1'b1;
                state_next    = status.srch_hit ? ST_C_INIT : ST_S_READ;
            end
            ST_C_INIT: begin
                cmd.clr_init = 1'b1;
                state_next   = ST_C_READ;
            end
            ST_C_READ: begin
                if (status.clr_end) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.clr_issue = 1'b1;
                    state_next    = ST_C_WRITE;
                end
            end
            ST_C_WRITE: begin
                cmd.clr_write = 1'b1;
                state_next    = ST_C_READ;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/psr_datapath.sv]
// Datapath of the prime sieve round block: bitmap memory, search and clear
// pointers, the max_number register and the output register. Uses psr_pkg.
module psr_datapath #(
    parameter int BITMAP_BYTES = 8192
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [psr_pkg::NUM_W-1:0]     cfg_max_number,
    input  logic [psr_pkg::REQ_W-1:0]     s_req_type,
    input  logic [psr_pkg::INDEX_W-1:0]   s_byte_index,
    input  logic [psr_pkg::BYTE_W-1:0]    s_byte_value,
    input  logic [psr_pkg::NUM_W-1:0]     s_prime_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psr_pkg::BYTE_W-1:0]    m_read_data,
    output logic [psr_pkg::NUM_W-1:0]     m_prime_out,
    output logic                          m_found,
    input  psr_pkg::cmd_t                 cmd,
    output psr_pkg::status_t              status
);

    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

    logic [psr_pkg::BYTE_W-1:0] mem [BITMAP_BYTES];
    logic [psr_pkg::BYTE_W-1:0] mem_rdata_reg;

    logic [psr_pkg::NUM_W-1:0]   max_reg;
    logic [psr_pkg::REQ_W-1:0]   req_reg;
    logic [psr_pkg::INDEX_W-1:0] idx_reg;
    logic [psr_pkg::BYTE_W-1:0]  val_reg;
    logic [psr_pkg::NUM_W-1:0]   p_reg;
    logic                        found_reg;
    logic [psr_pkg::WALK_W-1:0]  n_reg;
    logic [psr_pkg::WALK_W-1:0]  j_reg;
    logic [psr_pkg::BYTE_W-1:0]  rd_reg;

    logic                        m_valid_reg;
    logic [psr_pkg::BYTE_W-1:0]  m_read_data_reg;
    logic [psr_pkg::NUM_W-1:0]   m_prime_out_reg;
    logic                        m_found_reg;

    logic [psr_pkg::BADDR_W-1:0] idx_byte;
    logic [psr_pkg::BADDR_W-1:0] n_byte;
    logic [psr_pkg::BADDR_W-1:0] j_byte;
    logic                        idx_ok;
    logic                        n_ok;
    logic                        j_ok;
    logic [psr_pkg::BYTE_W-1:0]  low_mask;
    logic [psr_pkg::BYTE_W-1:0]  high_mask;
    logic [psr_pkg::BYTE_W-1:0]  cand;
    logic [2:0]                  hit_bit;
    logic [psr_pkg::WALK_W-1:0]  max_ext;
    logic                        mem_we;
    logic [psr_pkg::BADDR_W-1:0] mem_waddr;
    logic [psr_pkg::BYTE_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [psr_pkg::BADDR_W-1:0] mem_raddr;

    assign max_ext  = {1'b0, max_reg};
    assign idx_byte = {1'b0, idx_reg};
    assign n_byte   = n_reg[psr_pkg::WALK_W-1:3];
    assign j_byte   = j_reg[psr_pkg::WALK_W-1:3];
    assign idx_ok   = 32'(idx_byte) < 32'(BITMAP_BYTES);
    assign n_ok     = 32'(n_byte) < 32'(BITMAP_BYTES);
    assign j_ok     = 32'(j_byte) < 32'(BITMAP_BYTES);

    // Users must write configuration only while the block is idle; not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= psr_pkg::MAX_NUMBER_RESET;
        end else if (cfg_valid) begin
            max_reg <= cfg_max_number;
        end
    end

    // Bitmap memory: one write port, one registered read port.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_byte;
        mem_wdata = val_reg;
        if (cmd.byte_write) begin
            mem_we = idx_ok;
        end else if (cmd.clr_write) begin
            mem_we    = j_ok;
            mem_waddr = j_byte;
            mem_wdata = mem_rdata_reg & ~(8'd1 << j_reg[2:0]);
        end
    end

    always_comb begin
        mem_re    = cmd.rd_issue | cmd.srch_issue | cmd.clr_issue;
        mem_raddr = idx_byte;
        if (cmd.srch_issue) begin
            mem_raddr = n_byte;
        end else if (cmd.clr_issue) begin
            mem_raddr = j_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[AW'(mem_waddr)] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[AW'(mem_raddr)];
        end
    end

    // Candidates in the current byte: at or above the pointer, at or below max.
    assign low_mask  = 8'hFF << n_reg[2:0];
    assign high_mask = (n_byte == {1'b0, max_reg[psr_pkg::NUM_W-1:3]})
                     ? (8'hFF >> (3'd7 - max_reg[2:0])) : 8'hFF;
    assign cand      = n_ok ? (mem_rdata_reg & low_mask & high_mask) : '0;

    always_comb begin
        hit_bit = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (cand[i]) begin
                hit_bit = 3'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req_type;
            idx_reg <= s_byte_index;
            val_reg <= s_byte_value;
            p_reg   <= s_prime_in;
            rd_reg  <= '0;
        end
        if (cmd.rd_capture) begin
            rd_reg <= idx_ok ? mem_rdata_reg : '0;
        end
        if (cmd.srch_init) begin
            n_reg <= {1'b0, p_reg} + 1'b1;
        end
        if (cmd.srch_step) begin
            if (|cand) begin
                p_reg <= psr_pkg::NUM_W'({n_byte, hit_bit});
            end else begin
                n_reg <= {n_byte + 1'b1, 3'd0};
            end
        end
        if (cmd.clr_init) begin
            j_reg <= {p_reg, 1'b0};
        end
        if (cmd.clr_write) begin
            j_reg <= j_reg + {1'b0, p_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load) begin
            found_reg <= 1'b0;
        end else if (cmd.srch_step && (|cand)) begin
            found_reg <= 1'b1;
        end
    end

    assign status.srch_end = n_reg > max_ext;
    assign status.srch_hit = |cand;
    assign status.clr_end  = (p_reg < 16'd2) || (j_reg > max_ext);
    assign status.out_free = !m_valid_reg || m_ready;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_read_data_reg <= (req_reg == psr_pkg::REQ_READ) ? rd_reg : '0;
            m_prime_out_reg <= (req_reg == psr_pkg::REQ_ROUND) ? p_reg : '0;
            m_found_reg     <= (req_reg == psr_pkg::REQ_ROUND) && found_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_prime_out = m_prime_out_reg;
    assign m_found     = m_found_reg;

endmodule

[src/psr_checker.sv]
// Port-level checker for the prime sieve round block, bound to its top level.
// Depends only on psr_pkg for field widths.
module psr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [psr_pkg::BYTE_W-1:0]  m_read_data,
    input logic [psr_pkg::NUM_W-1:0]   m_prime_out,
    input logic                        m_found
);

    // A held result keeps its payload until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime_out)
            && $stable(m_read_data) && $stable(m_found))
        else $error("result changed while stalled");

    // One transaction at a time: the block is busy right after acceptance.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted on two consecutive cycles");

    // A round result that found a prime never carries read data.
    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_read_data == '0)
        else $error("round result with read data");

    // A read result with nonzero data carries no prime.
    a_read_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_data != '0) |-> (m_prime_out == '0) && !m_found)
        else $error("read result with prime fields");

    // No result is shown right after reset.
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule

bind prime_sieve_round psr_checker u_psr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_prime_out (m_prime_out),
    .m_found     (m_found)
);
